FILE: sv/cvc_pkg.sv
// Shared types, sizes and helper functions of the code value compactor.
// Used by cvc_front, cvc_back and code_value_compactor_unit; no dependencies.

package cvc_pkg;

  // Size of the code space; the bitmap holds one bit per code value.
  localparam int CODE_SPACE = 1024;

  localparam int OP_W       = 2;
  localparam int CV_W       = 10;
  localparam int NV_W       = 11;
  localparam int WORD_BITS  = 64;
  localparam int WORD_SH    = $clog2(WORD_BITS);
  localparam int WORD_COUNT = (CODE_SPACE + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int CNT_W      = $clog2(CODE_SPACE + 1);
  localparam int PC_W       = $clog2(WORD_BITS + 1);

  // Front queue between classification and execution.
  localparam int QDEPTH = 2;
  localparam int QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W   = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_CODE   = 1'b1;

  // Input op codes; the fourth code is dropped at the front.
  typedef enum logic [OP_W-1:0] {
    OP_MARK   = 2'd0,
    OP_XLATE  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    K_MARK  = 3'b001,
    K_XLATE = 3'b010,
    K_CLEAR = 3'b100
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [CV_W-1:0]  code;
  } item_t;

  typedef struct packed {
    logic             null_enable;
    logic [CV_W-1:0]  null_code;
  } cfg_t;

  function automatic logic in_space(input logic [CV_W-1:0] code);
    return int'(code) < CODE_SPACE;
  endfunction

  function automatic logic [WORD_AW-1:0] word_of(input logic [CV_W-1:0] code);
    return WORD_AW'(code >> WORD_SH);
  endfunction

  function automatic logic [PC_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + PC_W'(w[i]);
    end
    return n;
  endfunction

endpackage

FILE: sv/cvc_front.sv
// Front end: decodes the op of each input transfer and queues the item.
// Depends on cvc_pkg.

module cvc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [cvc_pkg::OP_W-1:0]   in_op,
  input  logic [cvc_pkg::CV_W-1:0]   in_code_value,
  output cvc_pkg::item_t             item,
  output logic                       item_valid,
  input  logic                       item_take
);
  import cvc_pkg::*;

  item_t             q_r [QDEPTH];
  logic [QA_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]   cnt_r, cnt_nxt;
  item_t             item_nxt;
  logic              keep;
  logic              push_ok;
  logic              pop_ok;

  // classify; the unused op code is taken and dropped
  always_comb begin
    item_nxt.code = in_code_value;
    item_nxt.kind = K_MARK;
    keep          = 1'b1;
    case (in_op)
      OP_MARK:  item_nxt.kind = K_MARK;
      OP_XLATE: item_nxt.kind = K_XLATE;
      OP_CLEAR: item_nxt.kind = K_CLEAR;
      default:  keep = 1'b0;
    endcase
  end

  assign in_full    = (cnt_r == QC_W'(QDEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rd_ptr_r];
  assign push_ok    = in_push && !in_full && keep;
  assign pop_ok     = item_take && item_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QC_W'(push_ok) - QC_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= item_nxt;
    end
  end

endmodule

FILE: sv/cvc_back.sv
// Back end: used-value bitmap memory, distinct count, rank scan sequencer
// and result register. Depends on cvc_pkg.

module cvc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cvc_pkg::cfg_t              cfg,
  input  cvc_pkg::item_t             item,
  input  logic                       item_valid,
  output logic                       item_take,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [cvc_pkg::NV_W-1:0]   out_new_value,
  output logic                       out_status
);
  import cvc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MARK = 5'b00010,
    ST_NULL = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CV_W-1:0]         v_r, v_nxt;
  logic [CNT_W-1:0]        acc_r, acc_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [WORD_COUNT-1:0]   wvalid_r, wvalid_nxt;
  logic [WORD_AW-1:0]      scan_r, scan_nxt;
  logic                    null_hit_r, null_hit_nxt;
  logic                    vbit_r, vbit_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [NV_W-1:0]         out_nv_r, out_nv_nxt;
  logic                    out_st_r, out_st_nxt;

  logic [WORD_BITS-1:0]    mem [WORD_COUNT];
  logic [WORD_BITS-1:0]    rd_data_r;
  logic [WORD_AW-1:0]      rd_addr_r;
  logic                    mem_re, mem_we;
  logic [WORD_AW-1:0]      mem_raddr;
  logic [WORD_BITS-1:0]    mem_wdata;

  logic [WORD_BITS-1:0]    rd_word;
  logic [WORD_SH-1:0]      rem;
  logic [WORD_AW-1:0]      last;
  logic [WORD_BITS-1:0]    low_mask;
  logic [WORD_BITS-1:0]    scan_word;
  logic [PC_W-1:0]         pc;
  logic                    out_free;
  logic                    null_is_v;
  logic                    null_below;
  logic [CNT_W-1:0]        xl;

  // words never written since the last clear read as zero
  assign rd_word   = wvalid_r[rd_addr_r] ? rd_data_r : '0;
  assign rem       = v_r[WORD_SH-1:0];
  assign last      = word_of(v_r);
  assign low_mask  = ({{(WORD_BITS-1){1'b0}}, 1'b1} << rem) - 1'b1;
  assign scan_word = (scan_r == last) ? (rd_word & low_mask) : rd_word;
  assign pc        = popcount(scan_word);
  assign out_free  = !out_valid_r || out_pop;
  assign mem_wdata = rd_word | ({{(WORD_BITS-1){1'b0}}, 1'b1} << rem);

  assign null_is_v  = null_hit_r && (v_r == cfg.null_code);
  assign null_below = null_hit_r && (cfg.null_code < v_r);
  assign xl = null_is_v ? (cnt_r - CNT_W'(1)) : (acc_r - CNT_W'(null_below));

  assign out_empty     = !out_valid_r;
  assign out_new_value = out_nv_r;
  assign out_status    = out_st_r;

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    wvalid_nxt    = wvalid_r;
    scan_nxt      = scan_r;
    null_hit_nxt  = null_hit_r;
    vbit_nxt      = vbit_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_nv_nxt    = out_nv_r;
    out_st_nxt    = out_st_r;
    item_take     = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_raddr     = scan_r;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          v_nxt     = item.code;
          case (item.kind)
            K_MARK: begin
              if (in_space(item.code)) begin
                mem_re    = 1'b1;
                mem_raddr = word_of(item.code);
                state_nxt = ST_MARK;
              end
            end
            K_XLATE: begin
              mem_re    = 1'b1;
              mem_raddr = word_of(cfg.null_code);
              acc_nxt   = '0;
              state_nxt = ST_NULL;
            end
            K_CLEAR: begin
              wvalid_nxt = '0;
              cnt_nxt    = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MARK: begin
        if (!rd_word[rem]) begin
          mem_we                = 1'b1;
          wvalid_nxt[rd_addr_r] = 1'b1;
          cnt_nxt               = cnt_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_NULL: begin
        null_hit_nxt = cfg.null_enable && in_space(cfg.null_code) &&
                       rd_word[cfg.null_code[WORD_SH-1:0]];
        if (in_space(v_r)) begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          scan_nxt  = '0;
          state_nxt = ST_SCAN;
        end else begin
          vbit_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end
      end
      ST_SCAN: begin
        acc_nxt = acc_r + CNT_W'(pc);
        if (scan_r == last) begin
          vbit_nxt  = rd_word[rem];
          state_nxt = ST_FIN;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = scan_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (!vbit_r) begin
            out_nv_nxt = NV_W'(v_r);
            out_st_nxt = 1'b1;
          end else begin
            out_nv_nxt = NV_W'(xl);
            out_st_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      wvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wvalid_r    <= wvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    acc_r      <= acc_nxt;
    scan_r     <= scan_nxt;
    null_hit_r <= null_hit_nxt;
    vbit_r     <= vbit_nxt;
    out_nv_r   <= out_nv_nxt;
    out_st_r   <= out_st_nxt;
  end

  // bitmap memory, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[rd_addr_r] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
      rd_addr_r <= mem_raddr;
    end
  end

endmodule

FILE: sv/code_value_compactor_unit.sv
// Top level of the code value compactor: configuration registers, front
// queue (cvc_front) and bitmap back end (cvc_back). Depends on cvc_pkg.

// Renumbers code values densely. Push a mark (op 0) for every used value,
// then a translate (op 1) for each value to get its rank among the marked
// values; op 2 clears the bitmap and count, op 3 is taken and ignored.
// With null_enable set and the null code marked, the null code translates
// to the number of other used values and drops out of every other rank.
// An unmarked or out-of-space value comes back unchanged with status 1.
// Only translates give results. In the back end a clear acts from idle,
// a mark reads its bitmap word, then writes it, and a translate reads the
// null code's word, then scans to the value's word: the rank scan reads one
// 64-bit bitmap word per cycle through the single read port and adds its
// popcount. A two-entry queue in front lets new transfers land while the
// back end works, and the result register frees the back end from a
// stalled reader. Write configuration only while the block is idle.

module code_value_compactor_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [cvc_pkg::OP_W-1:0]       in_op,
  input  logic [cvc_pkg::CV_W-1:0]       in_code_value,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [cvc_pkg::NV_W-1:0]       out_new_value,
  output logic                           out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cvc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvc_pkg::CV_W-1:0]       cfg_data
);
  import cvc_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  item_t  item;
  logic   item_valid;
  logic   item_take;

  // config channel never stalls
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_NULL_ENABLE: cfg_nxt.null_enable = cfg_data[0];
        CFG_NULL_CODE:   cfg_nxt.null_code   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.null_enable <= 1'b0;
      cfg_r.null_code   <= CV_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: decode and queue each input transfer
  cvc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_code_value (in_code_value),
    .item          (item),
    .item_valid    (item_valid),
    .item_take     (item_take)
  );

  // back: bitmap updates, rank scan, result register
  cvc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .item          (item),
    .item_valid    (item_valid),
    .item_take     (item_take),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_new_value (out_new_value),
    .out_status    (out_status)
  );

endmodule
